// File: hw/rtl/ohsp_pkg.sv
`default_nettype none

package ohsp_pkg;

   localparam int MAX_LEB_BYTES_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT   = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ANNEXB_MODE       = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD_BYTES = 1'b1;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd268435456;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_END       = 4'd1,
      ST_FORBIDDEN = 4'd2,
      ST_BADTYPE   = 4'd3,
      ST_NOSIZE    = 4'd4,
      ST_RESERVED  = 4'd5,
      ST_EXTRES    = 4'd6,
      ST_LEBLONG   = 4'd7,
      ST_OVER32    = 4'd8,
      ST_SMALL     = 4'd9,
      ST_TRUNC     = 4'd10,
      ST_LARGE     = 4'd11
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEN  = 3'd1,
      PH_HDR  = 3'd2,
      PH_EXT  = 3'd3,
      PH_SIZE = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  obu_kind;
      logic        ext_present;
      logic        size_present;
      logic [2:0]  temporal_id;
      logic [1:0]  spatial_id;
      logic [31:0] payload_len;
      logic [4:0]  prefix_bytes;
   } rsp_type;

   typedef struct packed {
      logic        annexb_mode;
      logic [31:0] max_payload_bytes;
   } cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/ohsp_fifo.sv
`default_nettype none

module ohsp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ohsp_parse.sv
`default_nettype none

module ohsp_parse #(
   parameter int MAX_LEB_BYTES = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ohsp_pkg::cfg_type cfg,
   input  wire logic             in_valid,
   input  wire ohsp_pkg::req_type in_data,
   output logic                  in_pop,
   input  wire logic             out_full,
   output logic                  out_push,
   output ohsp_pkg::rsp_type     out_data
);

   import ohsp_pkg::*;

   localparam int LEB_W = 7 * MAX_LEB_BYTES;
   localparam int CNT_W = $clog2(MAX_LEB_BYTES);

   phase_type        phase_ff, phase_in;
   logic [LEB_W-1:0] acc_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [31:0]      alen_ff;
   logic [3:0]       kind_ff;
   logic             ext_ff, sz_ff;
   logic [2:0]       tid_ff;
   logic [1:0]       sid_ff;
   logic [4:0]       cons_ff;

   logic             beat, emit;
   status_type       status;
   logic [31:0]      payload;
   logic [7:0]       b;
   logic             stream_end;
   logic             is_hdr, is_len, is_leb;
   logic [LEB_W-1:0] acc_base, acc_new;
   logic [CNT_W-1:0] cnt_base;
   logic             leb_cont, leb_long, leb_over;
   logic [3:0]       kind_b;
   logic             ext_b, sz_b, type_ok;
   logic [3:0]       kind_v;
   logic             ext_v, sz_v;
   logic [2:0]       tid_v;
   logic [1:0]       sid_v;
   logic [31:0]      alen_eff, hsize, ah_len, fin_val;
   logic             ah_small, fin_large;
   logic [4:0]       cons_inc, prefix_v;

   assign b          = in_data.data_byte;
   assign stream_end = in_data.stream_end;
   assign beat       = in_valid && !out_full;
   assign in_pop     = beat;
   assign out_push   = beat && emit;

   assign is_hdr = (phase_ff == PH_HDR) || ((phase_ff == PH_IDLE) && !cfg.annexb_mode);
   assign is_len = (phase_ff == PH_LEN) || ((phase_ff == PH_IDLE) && cfg.annexb_mode);
   assign is_leb = is_len || (phase_ff == PH_SIZE);

   // LEB128 assembly, one 7-bit group per beat
   assign acc_base = (phase_ff == PH_IDLE) ? '0 : acc_ff;
   assign cnt_base = (phase_ff == PH_IDLE) ? '0 : cnt_ff;
   assign leb_cont = b[7];
   assign leb_long = leb_cont && (cnt_base == CNT_W'(MAX_LEB_BYTES - 1));
   assign leb_over = |acc_new[LEB_W-1:32];

   always_comb begin
      acc_new = acc_base;
      for (int i = 0; i < MAX_LEB_BYTES; i++) begin
         if (cnt_base == CNT_W'(i)) begin
            acc_new[7*i +: 7] = b[6:0];
         end
      end
   end

   assign kind_b  = b[6:3];
   assign ext_b   = b[2];
   assign sz_b    = b[1];
   assign type_ok = ((kind_b != 4'd0) && (kind_b <= 4'd8)) || (kind_b == 4'd15);

   always_comb begin
      kind_v = kind_ff;
      ext_v  = ext_ff;
      sz_v   = sz_ff;
      tid_v  = tid_ff;
      sid_v  = sid_ff;
      if (!stream_end && is_hdr) begin
         kind_v = kind_b;
         ext_v  = ext_b;
         sz_v   = sz_b;
         tid_v  = '0;
         sid_v  = '0;
      end else if (!stream_end && (phase_ff == PH_EXT)) begin
         tid_v = b[7:5];
         sid_v = b[4:3];
      end
   end

   // payload from the Annex B length, or from the size field
   assign alen_eff  = (phase_ff == PH_IDLE) ? '0 : alen_ff;
   assign hsize     = (phase_ff == PH_EXT) ? 32'd2 : 32'd1;
   assign ah_small  = (alen_eff < hsize);
   assign ah_len    = alen_eff - hsize;
   assign fin_val   = (phase_ff == PH_SIZE) ? acc_new[31:0] : ah_len;
   assign fin_large = (fin_val > cfg.max_payload_bytes);

   assign cons_inc = cons_ff + 1'b1;
   assign prefix_v = stream_end ? ((phase_ff == PH_IDLE) ? '0 : cons_ff) : cons_inc;

   // result decision
   always_comb begin
      emit    = 1'b0;
      status  = ST_OK;
      payload = '0;
      if (in_valid) begin
         if (stream_end) begin
            emit   = 1'b1;
            status = (phase_ff == PH_IDLE) ? ST_END : ST_TRUNC;
         end else if (is_hdr) begin
            if (b[7]) begin
               emit   = 1'b1;
               status = ST_FORBIDDEN;
            end else if (!type_ok) begin
               emit   = 1'b1;
               status = ST_BADTYPE;
            end else if (!sz_b && !cfg.annexb_mode) begin
               emit   = 1'b1;
               status = ST_NOSIZE;
            end else if (b[0]) begin
               emit   = 1'b1;
               status = ST_RESERVED;
            end else if (!ext_b && !sz_b) begin
               emit = 1'b1;
               if (ah_small) begin
                  status = ST_SMALL;
               end else begin
                  status  = fin_large ? ST_LARGE : ST_OK;
                  payload = fin_val;
               end
            end
         end else if (is_len) begin
            if (leb_long) begin
               emit   = 1'b1;
               status = ST_LEBLONG;
            end else if (!leb_cont && leb_over) begin
               emit   = 1'b1;
               status = ST_OVER32;
            end
         end else if (phase_ff == PH_EXT) begin
            if (b[2:0] != 3'd0) begin
               emit   = 1'b1;
               status = ST_EXTRES;
            end else if (!sz_ff) begin
               emit = 1'b1;
               if (ah_small) begin
                  status = ST_SMALL;
               end else begin
                  status  = fin_large ? ST_LARGE : ST_OK;
                  payload = fin_val;
               end
            end
         end else if (phase_ff == PH_SIZE) begin
            if (leb_long) begin
               emit   = 1'b1;
               status = ST_LEBLONG;
            end else if (!leb_cont) begin
               emit = 1'b1;
               if (leb_over) begin
                  status = ST_OVER32;
               end else begin
                  status  = fin_large ? ST_LARGE : ST_OK;
                  payload = fin_val;
               end
            end
         end
      end
   end

   always_comb begin
      out_data.status       = status;
      out_data.obu_kind     = kind_v;
      out_data.ext_present  = ext_v;
      out_data.size_present = sz_v;
      out_data.temporal_id  = tid_v;
      out_data.spatial_id   = sid_v;
      out_data.payload_len  = payload;
      out_data.prefix_bytes = prefix_v;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (beat) begin
         if (emit) begin
            phase_in = PH_IDLE;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (cfg.annexb_mode) begin
                     phase_in = leb_cont ? PH_LEN : PH_HDR;
                  end else begin
                     phase_in = ext_b ? PH_EXT : PH_SIZE;
                  end
               end
               PH_LEN:  phase_in = leb_cont ? PH_LEN : PH_HDR;
               PH_HDR:  phase_in = ext_b ? PH_EXT : PH_SIZE;
               PH_EXT:  phase_in = PH_SIZE;
               PH_SIZE: phase_in = PH_SIZE;
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         cons_ff  <= '0;
         kind_ff  <= '0;
         ext_ff   <= 1'b0;
         sz_ff    <= 1'b0;
         tid_ff   <= '0;
         sid_ff   <= '0;
         alen_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         if (beat) begin
            if (emit) begin
               cnt_ff  <= '0;
               cons_ff <= '0;
               kind_ff <= '0;
               ext_ff  <= 1'b0;
               sz_ff   <= 1'b0;
               tid_ff  <= '0;
               sid_ff  <= '0;
            end else begin
               cnt_ff  <= is_leb ? cnt_base + 1'b1 : '0;
               cons_ff <= cons_inc;
               kind_ff <= kind_v;
               ext_ff  <= ext_v;
               sz_ff   <= sz_v;
               tid_ff  <= tid_v;
               sid_ff  <= sid_v;
            end
            if (!stream_end && (phase_ff == PH_IDLE) && !cfg.annexb_mode) begin
               alen_ff <= '0;
            end else if (!stream_end && is_len && !leb_cont && !leb_over) begin
               alen_ff <= acc_new[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         acc_ff <= (is_leb && !emit) ? acc_new : '0;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/obu_header_and_size_parser.sv
// AV1 OBU prefix parser.
// Stream bytes enter through a queue port: req_data is taken when push is
// high and full is low, one beat per byte, stream_end marking the end.
// Each OBU prefix (optional Annex B length, header, extension, size field)
// gives one rsp_data beat, shown while empty is low and taken with pop.
// Configuration: csr_we writes csr_wdata to register csr_index
// (0 annexb_mode, 1 max_payload_bytes); write only while the block is idle.
// Throughput: one byte per cycle while the result queue is not full.
// Path: the byte completing a result waits in the input queue, then the parser
// pushes the result into the result queue, which drives the rsp ports.
// When pop stays low the result queue fills, the parser holds, and full
// rises once the input queue is also full; nothing is dropped.
// Reset (synchronous, active high) empties both queues, returns the
// parser to waiting for an OBU start and restores register defaults.
`default_nettype none

module obu_header_and_size_parser #(
   parameter int MAX_LEB_BYTES = ohsp_pkg::MAX_LEB_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH   = ohsp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire ohsp_pkg::req_type                  req_data,
   output logic                                    full,
   output logic                                    empty,
   input  wire logic                               pop,
   output ohsp_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [ohsp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ohsp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import ohsp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   req_type in_head;
   rsp_type res_data;
   logic    in_empty, in_pop;
   logic    res_full, res_push;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ANNEXB_MODE:       cfg_in.annexb_mode       = csr_wdata[0];
            CSR_MAX_PAYLOAD_BYTES: cfg_in.max_payload_bytes = csr_wdata[31:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.annexb_mode       <= 1'b0;
         cfg_ff.max_payload_bytes <= MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ohsp_fifo #(
      .WIDTH ($bits(req_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (req_data),
      .full      (full),
      .pop       (in_pop),
      .pop_data  (in_head),
      .empty     (in_empty)
   );

   ohsp_parse #(
      .MAX_LEB_BYTES (MAX_LEB_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (!in_empty),
      .in_data  (in_head),
      .in_pop   (in_pop),
      .out_full (res_full),
      .out_push (res_push),
      .out_data (res_data)
   );

   ohsp_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

   a_reset_clears: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_end_no_prefix: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.status == ST_END)) |->
         ((rsp_data.prefix_bytes == 5'd0) && (rsp_data.payload_len == 32'd0)))
      else $error("end beat carries prefix or payload");

   a_error_no_payload: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.payload_len != 32'd0)) |->
         ((rsp_data.status == ST_OK) || (rsp_data.status == ST_LARGE)))
      else $error("error beat carries payload length");

   a_no_push_to_full: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_full) |-> 1'b0)
      else $error("result pushed into full queue");

endmodule

`default_nettype wire
